/* sv/ibc_pkg.sv */
package ibc_pkg;

    localparam int unsigned ANG_W = 32;
    localparam int unsigned VEC_W = 34;
    localparam int unsigned PROD_W = 66;
    localparam int unsigned KINV_Q30 = 652032874;
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] ADDR_GOAL_LAT = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_GOAL_LON = 3'd4;

    typedef logic [ANG_W-1:0] t_bam;
    typedef logic signed [VEC_W-1:0] t_vec;

    // Arctangent of 2^-k as a 32-bit binary angle.
    function automatic t_bam atan_lut(input logic [4:0] k);
        t_bam r;
        case (k)
            5'd0: r = 32'h20000000;
            5'd1: r = 32'h12E4051E;
            5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4;
            5'd4: r = 32'h028B0D43;
            5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E;
            5'd7: r = 32'h00517C55;
            5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

/* sv/ibc_if.sv */
interface ibc_pos_if;
    logic valid;
    logic ready;
    logic signed [30:0] here_latitude;
    logic signed [31:0] here_longitude;
    modport source (output valid, here_latitude, here_longitude, input ready);
    modport sink (input valid, here_latitude, here_longitude, output ready);
endinterface

interface ibc_head_if;
    logic valid;
    logic ready;
    logic [15:0] heading_angle;
    modport source (output valid, heading_angle, input ready);
    modport sink (input valid, heading_angle, output ready);
endinterface

/* sv/ibc_bam.sv */
// Degree units of 1e-7 to a 32-bit binary angle, rounded half away from zero.
// Registered three times: reciprocal product, quotient estimate, then the
// remainder correction and the sign.
module ibc_bam (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [31:0]   i_deg,
    output ibc_pkg::t_bam        o_bam
);
    import ibc_pkg::*;

    // q = floor((mag * 2^28 + 112500000) / 225000000)
    localparam logic [33:0] RECIP = 34'd5124095576; // floor(2^32 * 2^32 / 3.6e9)
    localparam logic [31:0] DIV_C = 32'd225000000;
    localparam logic [31:0] HALF_C = 32'd112500000;
    logic [31:0] mag;
    logic [65:0] n_prod;
    logic [65:0] r_prod;
    logic [3:0]  r_mag_lo;
    logic        r_neg;
    logic        r_neg2;
    logic [31:0] n_q;
    logic [31:0] r_q;
    logic [31:0] r_num;
    logic [31:0] rem;
    logic [31:0] q_fix;
    logic [31:0] r_bam;

    assign mag = i_deg[31] ? 32'(-i_deg) : i_deg;
    assign n_prod = 66'(mag) * 66'(RECIP);

    // The truncated reciprocal never overshoots, so the estimate is either
    // the exact quotient or one below it.
    assign n_q = 32'((r_prod + (66'd1 << 31)) >> 32);

    // The true remainder is below twice the divisor, so its low 32 bits suffice.
    assign rem = r_num - r_q * DIV_C;
    assign q_fix = (rem >= DIV_C) ? r_q + 32'd1 : r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_mag_lo <= mag[3:0];
            r_neg <= i_deg[31];
            r_q <= n_q;
            r_num <= {r_mag_lo, 28'd0} + HALF_C;
            r_neg2 <= r_neg;
            r_bam <= r_neg2 ? 32'd0 - q_fix : q_fix;
        end
    end

    assign o_bam = r_bam;
endmodule

/* sv/ibc_rot_cell.sv */
// One rotation-mode CORDIC iteration.
module ibc_rot_cell #(
    parameter int unsigned K = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  ibc_pkg::t_vec        i_x,
    input  ibc_pkg::t_vec        i_y,
    input  logic signed [32:0]   i_z,
    input  logic                 i_flip,
    output ibc_pkg::t_vec        o_x,
    output ibc_pkg::t_vec        o_y,
    output logic signed [32:0]   o_z,
    output logic                 o_flip
);
    import ibc_pkg::*;

    localparam logic signed [32:0] ATAN = 33'(atan_lut(5'(K % 32)));
    t_vec dx;
    t_vec dy;
    t_vec r_x;
    t_vec r_y;
    logic signed [32:0] r_z;
    logic r_flip;

    assign dx = i_y >>> (K % 32);
    assign dy = i_x >>> (K % 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[32]) begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - ATAN;
            end else begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + ATAN;
            end
            r_flip <= i_flip;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_flip = r_flip;
endmodule

/* sv/ibc_vec_cell.sv */
// One vectoring-mode CORDIC iteration.
module ibc_vec_cell #(
    parameter int unsigned K = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  ibc_pkg::t_vec        i_a,
    input  ibc_pkg::t_vec        i_b,
    input  ibc_pkg::t_bam        i_z,
    output ibc_pkg::t_vec        o_a,
    output ibc_pkg::t_vec        o_b,
    output ibc_pkg::t_bam        o_z
);
    import ibc_pkg::*;

    localparam t_bam ATAN = atan_lut(5'(K % 32));
    t_vec da;
    t_vec db;
    t_vec r_a;
    t_vec r_b;
    t_bam r_z;

    assign da = i_b >>> (K % 32);
    assign db = i_a >>> (K % 32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_b > 0) begin
                r_a <= i_a + da;
                r_b <= i_b - db;
                r_z <= i_z + ATAN;
            end else begin
                r_a <= i_a - da;
                r_b <= i_b + db;
                r_z <= i_z - ATAN;
            end
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_z = r_z;
endmodule

/* sv/initial_bearing_calc_unit.sv */
// Great-circle initial bearing from the position on the input channel to the
// target position held in two APB registers (goal latitude at 0x0, goal
// longitude at 0x4, both in signed units of 1e-7 degree).
// Input channel: here_latitude / here_longitude, one transfer per position.
// Output channel: heading_angle, a binary angle of 2^HEADING_BITS per turn,
// clockwise from north, one transfer per input transfer, in order.
// The datapath is a single pipeline: three angle conversion stages, three
// rotation CORDIC rows of CORDIC_STAGES cells each after a seeding stage, two
// product stages, a normalising shifter stage, a vectoring CORDIC row and a
// rounding stage. One position can be taken every cycle while the output is
// not stalled.
// The whole pipeline advances only when its last stage is empty or being
// taken, so a stalled receiver holds every stage and ready drops straight
// away; nothing is lost or repeated.
// Reset clears the valid bits of the pipeline and both goal registers.
// Goal registers should only be written while no position is in flight.
module initial_bearing_calc_unit #(
    parameter int unsigned CORDIC_STAGES = 16,
    parameter int unsigned HEADING_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ibc_pos_if.sink                      i_pos,
    ibc_head_if.source                   o_head,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ibc_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ibc_pkg::*;

    localparam int unsigned LAT = 2 * CORDIC_STAGES + 8;

    logic signed [30:0] r_goal_lat;
    logic signed [31:0] r_goal_lon;
    logic [LAT-1:0] r_vld;
    logic adv;

    assign pready = 1'b1;
    always_comb begin
        case (paddr)
            ADDR_GOAL_LAT: prdata = 32'(r_goal_lat);
            ADDR_GOAL_LON: prdata = r_goal_lon;
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_lat <= '0;
            r_goal_lon <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_GOAL_LAT) r_goal_lat <= pwdata[30:0];
            if (paddr == ADDR_GOAL_LON) r_goal_lon <= pwdata;
        end
    end

    assign adv = !r_vld[LAT-1] || o_head.ready;
    assign i_pos.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_pos.valid};
        end
    end

    // Stages 1-3: angle conversion.
    t_bam lat1;
    t_bam lon1;
    t_bam lat2;
    t_bam lon2;
    ibc_bam u_lat1 (.i_clk, .i_en(adv), .i_deg(32'(i_pos.here_latitude)), .o_bam(lat1));
    ibc_bam u_lon1 (.i_clk, .i_en(adv), .i_deg(i_pos.here_longitude), .o_bam(lon1));
    ibc_bam u_lat2 (.i_clk, .i_en(adv), .i_deg(32'(r_goal_lat)), .o_bam(lat2));
    ibc_bam u_lon2 (.i_clk, .i_en(adv), .i_deg(r_goal_lon), .o_bam(lon2));

    // Stage 4: fold into the right half-plane and seed the rotators.
    t_bam dlon;
    t_bam ang [3];
    logic r_same;
    logic r_dz;
    t_vec rx [3][CORDIC_STAGES+1];
    t_vec ry [3][CORDIC_STAGES+1];
    logic signed [32:0] rz [3][CORDIC_STAGES+1];
    logic rf [3][CORDIC_STAGES+1];
    logic [CORDIC_STAGES-1:0] r_same_d;
    logic [CORDIC_STAGES-1:0] r_dz_d;

    assign dlon = lon2 - lon1;
    assign ang[0] = lat1;
    assign ang[1] = lat2;
    assign ang[2] = dlon;

    for (genvar u = 0; u < 3; u++) begin : g_rot
        t_bam fa;
        logic fl;
        t_vec r_x0;
        logic signed [32:0] r_z0;
        logic r_f0;
        t_bam tmp;
        assign tmp = ang[u] + 32'h40000000;
        assign fl = tmp[31];
        assign fa = fl ? ang[u] - 32'h80000000 : ang[u];
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_x0 <= VEC_W'(KINV_Q30);
                r_z0 <= 33'($signed(fa));
                r_f0 <= fl;
            end
        end
        assign rx[u][0] = r_x0;
        assign ry[u][0] = '0;
        assign rz[u][0] = r_z0;
        assign rf[u][0] = r_f0;
        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
            ibc_rot_cell #(.K(k)) u_cell (
                .i_clk, .i_en(adv),
                .i_x(rx[u][k]), .i_y(ry[u][k]), .i_z(rz[u][k]), .i_flip(rf[u][k]),
                .o_x(rx[u][k+1]), .o_y(ry[u][k+1]), .o_z(rz[u][k+1]),
                .o_flip(rf[u][k+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_same <= (lat1 == lat2) && (dlon == '0);
            r_dz <= (dlon == '0);
            r_same_d <= {r_same_d[CORDIC_STAGES-2:0], r_same};
            r_dz_d <= {r_dz_d[CORDIC_STAGES-2:0], r_dz};
        end
    end

    t_vec s1;
    t_vec c1;
    t_vec s2;
    t_vec c2;
    t_vec sd;
    t_vec cd;
    assign s1 = rf[0][CORDIC_STAGES] ? -ry[0][CORDIC_STAGES] : ry[0][CORDIC_STAGES];
    assign c1 = rf[0][CORDIC_STAGES] ? -rx[0][CORDIC_STAGES] : rx[0][CORDIC_STAGES];
    assign s2 = rf[1][CORDIC_STAGES] ? -ry[1][CORDIC_STAGES] : ry[1][CORDIC_STAGES];
    assign c2 = rf[1][CORDIC_STAGES] ? -rx[1][CORDIC_STAGES] : rx[1][CORDIC_STAGES];
    assign sd = rf[2][CORDIC_STAGES] ? -ry[2][CORDIC_STAGES] : ry[2][CORDIC_STAGES];
    assign cd = rf[2][CORDIC_STAGES] ? -rx[2][CORDIC_STAGES] : rx[2][CORDIC_STAGES];

    // Product stage A: three products, each 34x34.
    logic signed [PROD_W-1:0] r_east;
    logic signed [PROD_W-1:0] r_c1s2;
    logic signed [PROD_W-1:0] r_s1c2;
    t_vec r_cd;
    logic r_same_a;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_east <= r_dz_d[CORDIC_STAGES-1] ? '0 : PROD_W'(sd) * PROD_W'(c2);
            r_c1s2 <= PROD_W'(c1) * PROD_W'(s2);
            r_s1c2 <= PROD_W'(s1) * PROD_W'(c2);
            r_cd <= cd;
            r_same_a <= r_same_d[CORDIC_STAGES-1];
        end
    end

    // Product stage B: north = c1*s2 - floor(s1*c2 / 2^30) * cd.
    t_vec tq;
    logic signed [PROD_W-1:0] r_east_b;
    logic signed [PROD_W-1:0] r_north;
    logic r_same_b;
    assign tq = VEC_W'(r_s1c2 >>> 30);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_east_b <= r_east;
            r_north <= r_c1s2 - PROD_W'(tq) * PROD_W'(r_cd);
            r_same_b <= r_same_a;
        end
    end

    // Normalise: halve both until each magnitude is below 2^30. The shift
    // count comes from the top bit of the sign-folded words; a negative word
    // that then lands exactly on -2^30 needs one more halving.
    localparam t_vec VEC_NEG_LIM = -34'sd1073741824;
    logic [PROD_W-1:0] ma;
    logic [PROD_W-1:0] mb;
    logic [PROD_W-1:0] mor;
    logic [6:0] sh;
    t_vec na0;
    t_vec nb0;
    logic extra;
    t_vec na;
    t_vec nb;
    t_vec r_a0;
    t_vec r_b0;
    t_bam r_z0;
    logic r_spec;
    logic r_spec_v;
    logic [CORDIC_STAGES-1:0] r_spec_d;
    logic [CORDIC_STAGES-1:0] r_spv_d;
    assign ma = r_north ^ {PROD_W{r_north[PROD_W-1]}};
    assign mb = r_east_b ^ {PROD_W{r_east_b[PROD_W-1]}};
    assign mor = ma | mb;
    always_comb begin
        sh = '0;
        for (int j = 30; j < PROD_W; j++) begin
            if (mor[j]) sh = 7'(j - 29);
        end
    end
    assign na0 = VEC_W'(r_north >>> sh);
    assign nb0 = VEC_W'(r_east_b >>> sh);
    assign extra = (na0 == VEC_NEG_LIM) || (nb0 == VEC_NEG_LIM);
    assign na = extra ? (na0 >>> 1) : na0;
    assign nb = extra ? (nb0 >>> 1) : nb0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_spec <= r_same_b || (r_east_b == '0);
            r_spec_v <= !r_same_b && (r_north < 0);
            if (na < 0) begin
                r_a0 <= -na;
                r_b0 <= -nb;
                r_z0 <= 32'h80000000;
            end else begin
                r_a0 <= na;
                r_b0 <= nb;
                r_z0 <= '0;
            end
            r_spec_d <= {r_spec_d[CORDIC_STAGES-2:0], r_spec};
            r_spv_d <= {r_spv_d[CORDIC_STAGES-2:0], r_spec_v};
        end
    end

    t_vec va [CORDIC_STAGES+1];
    t_vec vb [CORDIC_STAGES+1];
    t_bam vz [CORDIC_STAGES+1];
    assign va[0] = r_a0;
    assign vb[0] = r_b0;
    assign vz[0] = r_z0;
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        ibc_vec_cell #(.K(k)) u_cell (
            .i_clk, .i_en(adv),
            .i_a(va[k]), .i_b(vb[k]), .i_z(vz[k]),
            .o_a(va[k+1]), .o_b(vb[k+1]), .o_z(vz[k+1])
        );
    end

    // Final stage: special cases, round to HEADING_BITS.
    t_bam brg;
    t_bam hr;
    logic [15:0] r_head;
    assign brg = r_spec_d[CORDIC_STAGES-1]
               ? (r_spv_d[CORDIC_STAGES-1] ? 32'h80000000 : 32'h0)
               : vz[CORDIC_STAGES];
    assign hr = (brg + (32'd1 << (31 - HEADING_BITS))) >> (32 - HEADING_BITS);
    always_ff @(posedge i_clk) begin
        if (adv) r_head <= 16'(hr);
    end

    assign o_head.valid = r_vld[LAT-1];
    assign o_head.heading_angle = r_head;
endmodule

/* sv/ibc_checker.sv */
module ibc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] heading
);
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |-> !in_ready) else $error("input taken while stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(heading)))
        else $error("result changed while stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind initial_bearing_calc_unit ibc_checker u_ibc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_pos.ready),
    .out_valid(o_head.valid), .out_ready(o_head.ready),
    .heading(o_head.heading_angle)
);
